[rtl/pfte_pkg.sv]
// pfte_pkg: shared types, constants and font table for the page frame buffer text engine
// no dependencies
package pfte_pkg;

  localparam int DEF_PANEL_WIDTH  = 128;
  localparam int DEF_PANEL_HEIGHT = 64;
  localparam int NUM_PAGES        = 8;
  localparam int MAX_DATA_COLS    = 135;
  localparam logic [7:0] FIRST_CODE = 8'd32;
  localparam logic [7:0] LAST_CODE  = 8'd127;
  localparam logic [7:0] CMD_CTRL   = 8'h00;
  localparam logic [7:0] CMD_PAGE   = 8'hB0;
  localparam logic [7:0] CMD_COL_LO = 8'h00;
  localparam logic [7:0] CMD_COL_HI = 8'h10;
  localparam logic [7:0] DATA_CTRL  = 8'h40;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_PIXEL = 2'd1,
    OP_GLYPH = 2'd2,
    OP_SHOW  = 2'd3
  } op_t;

  // controller -> datapath commands
  typedef struct packed {
    logic       load;       // capture the input item
    logic       clr_wr;     // write zero at the sweep address
    logic       pix_rd;     // read the byte under the current pixel
    logic       pix_wr;     // write back the modified byte
    logic       pix_next;   // advance glyph pixel counters
    logic       cmd_emit;   // load a command word into the output register
    logic [1:0] cmd_sel;
    logic       dat_rd;     // read one data byte
    logic       dat_pack;   // pack the read byte into the word buffer
    logic       dat_emit;   // move the word buffer to the output register
    logic       cnt_clr;
  } pfte_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic clr_done;
    logic glyph_done;
    logic word_full;
    logic data_done;
    logic out_busy;
    logic code_ok;
  } pfte_sts_t;

  function automatic logic [7:0] glyph_col(input logic [7:0] code, input logic [2:0] col);
    logic [39:0] g;
    begin
      case (code)
        8'd48:   g = 40'h3E_45_49_51_3E;
        8'd49:   g = 40'h00_40_7F_42_00;
        8'd50:   g = 40'h46_49_51_61_42;
        8'd51:   g = 40'h31_4B_45_41_21;
        8'd65:   g = 40'h7E_11_11_11_7E;
        8'd66:   g = 40'h36_49_49_49_7F;
        8'd67:   g = 40'h22_41_41_41_3E;
        default: g = 40'h0;
      endcase
      case (col)
        3'd0:    glyph_col = g[7:0];
        3'd1:    glyph_col = g[15:8];
        3'd2:    glyph_col = g[23:16];
        3'd3:    glyph_col = g[31:24];
        3'd4:    glyph_col = g[39:32];
        default: glyph_col = 8'h00;
      endcase
    end
  endfunction

endpackage

[rtl/pfte_if.sv]
// pfte_in_if / pfte_out_if: valid/ready channels for items and transfer words
// depends on nothing
interface pfte_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  logic signed [9:0] x_pos;
  logic signed [9:0] y_pos;
  logic              pixel_on;
  logic [7:0]        char_code;
  logic [2:0]        page_index;
  modport source (output valid, operation, x_pos, y_pos, pixel_on, char_code, page_index,
                  input ready);
  modport sink (input valid, operation, x_pos, y_pos, pixel_on, char_code, page_index,
                output ready);
endinterface

interface pfte_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] bus_bytes;
  logic [3:0]  byte_count;
  logic        transfer_start;
  logic        transfer_end;
  logic        last_of_flush;
  modport source (output valid, bus_bytes, byte_count, transfer_start, transfer_end,
                  last_of_flush, input ready);
  modport sink (input valid, bus_bytes, byte_count, transfer_start, transfer_end,
                last_of_flush, output ready);
endinterface

[rtl/pfte_datapath.sv]
// pfte_datapath: frame store memory, pixel/glyph addressing, flush word packing, output register
// depends on pfte_pkg
module pfte_datapath #(
  parameter int PANEL_WIDTH  = pfte_pkg::DEF_PANEL_WIDTH,
  parameter int PANEL_HEIGHT = pfte_pkg::DEF_PANEL_HEIGHT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pfte_pkg::pfte_cmd_t cmd,
  output pfte_pkg::pfte_sts_t sts,
  input  logic [1:0]          in_operation,
  input  logic signed [9:0]   in_x_pos,
  input  logic signed [9:0]   in_y_pos,
  input  logic                in_pixel_on,
  input  logic [7:0]          in_char_code,
  input  logic [2:0]          in_page_index,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [63:0]         out_bus_bytes,
  output logic [3:0]          out_byte_count,
  output logic                out_transfer_start,
  output logic                out_transfer_end,
  output logic                out_last_of_flush
);
  localparam int DEPTH  = PANEL_WIDTH * pfte_pkg::NUM_PAGES;
  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = $clog2(PANEL_WIDTH);
  localparam int NCOLS  = (PANEL_WIDTH < pfte_pkg::MAX_DATA_COLS) ? PANEL_WIDTH
                                                                  : pfte_pkg::MAX_DATA_COLS;
  localparam int TOTAL  = NCOLS + 1;
  localparam int SW     = $clog2(TOTAL + 1);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_r;

  logic                op_on_r;
  logic signed [10:0]  x_r, y_r;
  logic [7:0]          code_r;
  logic [2:0]          page_r;
  logic [2:0]          gc_r, gr_r;
  logic [AW:0]         clr_r;
  logic [SW-1:0]       s_r;      // stream position: 0 is the control byte
  logic [3:0]          b_r;      // bytes in word buffer
  logic [63:0]         wbuf_r;
  logic                first_r;

  // current pixel
  logic signed [10:0] px, py;
  logic               pon, pin;
  logic [AW-1:0]      paddr;
  logic [7:0]         pmask;
  logic [7:0]         gbits;
  always_comb begin
    gbits = pfte_pkg::glyph_col(code_r, gc_r);
    px  = x_r + 11'(gc_r);
    py  = y_r + 11'(gr_r);
    pon = gbits[gr_r];
    pin = (px >= 0) && (px < 11'(PANEL_WIDTH)) && (py >= 0) && (py < 11'(PANEL_HEIGHT));
    paddr = AW'((32'(py) >> 3) * PANEL_WIDTH + 32'(px));
    pmask = 8'(1) << py[2:0];
  end
  logic pix_mode_r; // 1: single pixel, use pixel_on

  // data byte address
  logic [AW-1:0] daddr;
  assign daddr = AW'(32'(page_r) * PANEL_WIDTH + 32'(s_r) - 32'd1);

  always_ff @(posedge clk) begin
    if (cmd.clr_wr) mem[clr_r[AW-1:0]] <= 8'h00;
    else if (cmd.pix_wr && pin)
      mem[paddr] <= (pix_mode_r ? op_on_r : pon) ? (rd_r | pmask) : (rd_r & ~pmask);
    if (cmd.pix_rd) rd_r <= mem[paddr];
    else if (cmd.dat_rd) rd_r <= mem[daddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0; gc_r <= '0; gr_r <= '0; s_r <= '0; b_r <= '0; first_r <= 1'b1;
    end else begin
      if (cmd.load) begin
        x_r <= 11'(in_x_pos); y_r <= 11'(in_y_pos);
        code_r <= in_char_code; page_r <= in_page_index;
        op_on_r <= in_pixel_on;
        pix_mode_r <= (in_operation == pfte_pkg::OP_PIXEL);
      end
      if (cmd.cnt_clr) begin
        clr_r <= '0; gc_r <= '0; gr_r <= '0; s_r <= '0; b_r <= '0; first_r <= 1'b1;
        wbuf_r <= '0;
      end
      if (cmd.clr_wr) clr_r <= clr_r + 1'b1;
      if (cmd.pix_next) begin
        if (gr_r == 3'd6) begin gr_r <= '0; gc_r <= gc_r + 3'd1; end
        else gr_r <= gr_r + 3'd1;
      end
      if (cmd.dat_pack) begin
        wbuf_r[8*b_r[2:0] +: 8] <= (s_r == '0) ? pfte_pkg::DATA_CTRL : rd_r;
        b_r <= b_r + 4'd1;
        s_r <= s_r + 1'b1;
      end
      if (cmd.dat_emit) begin
        b_r <= '0; wbuf_r <= '0; first_r <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else begin
      if (cmd.cmd_emit) begin
        out_valid <= 1'b1;
        out_byte_count <= 4'd2;
        out_transfer_start <= 1'b1; out_transfer_end <= 1'b1; out_last_of_flush <= 1'b0;
        case (cmd.cmd_sel)
          2'd0:    out_bus_bytes <= {48'h0, pfte_pkg::CMD_PAGE + {5'h0, page_r},
                                     pfte_pkg::CMD_CTRL};
          2'd1:    out_bus_bytes <= {48'h0, pfte_pkg::CMD_COL_LO, pfte_pkg::CMD_CTRL};
          default: out_bus_bytes <= {48'h0, pfte_pkg::CMD_COL_HI, pfte_pkg::CMD_CTRL};
        endcase
      end else if (cmd.dat_emit) begin
        out_valid <= 1'b1;
        out_bus_bytes <= wbuf_r;
        out_byte_count <= b_r;
        out_transfer_start <= first_r;
        out_transfer_end <= (32'(s_r) == TOTAL);
        out_last_of_flush <= (32'(s_r) == TOTAL);
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign sts.clr_done   = (32'(clr_r) == DEPTH - 1);
  assign sts.glyph_done = pix_mode_r || (gc_r == 3'd4 && gr_r == 3'd6);
  assign sts.word_full  = (b_r == 4'd8);
  assign sts.data_done  = (32'(s_r) == TOTAL);
  assign sts.out_busy   = out_valid && !out_ready;
  assign sts.code_ok    = (in_char_code >= pfte_pkg::FIRST_CODE) &&
                          (in_char_code <= pfte_pkg::LAST_CODE);
endmodule

[rtl/pfte_ctrl.sv]
// pfte_ctrl: sequencer for clear, pixel, glyph and page flush operations
// depends on pfte_pkg
module pfte_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_operation,
  output pfte_pkg::pfte_cmd_t cmd,
  input  pfte_pkg::pfte_sts_t sts
);
  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_PRD, S_PWR, S_CMD, S_DRD, S_DWAIT, S_DPACK, S_DEMIT
  } state_t;
  state_t state_r, state_nxt;
  logic [1:0] sel_r, sel_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r; sel_nxt = sel_r; cmd = '0;
    case (state_r)
      S_IDLE: if (in_valid) begin
        cmd.load = 1'b1; cmd.cnt_clr = 1'b1; sel_nxt = 2'd0;
        case (in_operation)
          pfte_pkg::OP_CLEAR: state_nxt = S_CLR;
          pfte_pkg::OP_PIXEL: state_nxt = S_PRD;
          pfte_pkg::OP_GLYPH: state_nxt = sts.code_ok ? S_PRD : S_IDLE;
          default:            state_nxt = S_CMD;
        endcase
      end
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_PRD: begin cmd.pix_rd = 1'b1; state_nxt = S_PWR; end
      S_PWR: begin
        cmd.pix_wr = 1'b1;
        if (sts.glyph_done) state_nxt = S_IDLE;
        else begin cmd.pix_next = 1'b1; state_nxt = S_PRD; end
      end
      S_CMD: if (!sts.out_busy) begin
        cmd.cmd_emit = 1'b1; cmd.cmd_sel = sel_r; sel_nxt = sel_r + 2'd1;
        if (sel_r == 2'd2) state_nxt = S_DPACK;
      end
      S_DRD: begin cmd.dat_rd = 1'b1; state_nxt = S_DPACK; end
      S_DPACK: begin
        if (sts.data_done || sts.word_full) state_nxt = S_DEMIT;
        else begin cmd.dat_pack = 1'b1; state_nxt = S_DWAIT; end
      end
      S_DWAIT: state_nxt = sts.data_done ? S_DEMIT : S_DRD;
      S_DEMIT: if (!sts.out_busy) begin
        cmd.dat_emit = 1'b1;
        state_nxt = sts.data_done ? S_IDLE : S_DRD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin state_r <= S_CLR; sel_r <= '0; end
    else begin state_r <= state_nxt; sel_r <= sel_nxt; end
  end
endmodule

[rtl/page_framebuffer_text_engine.sv]
// Monochrome page frame store with 5x7 text and page flush. Items are taken one at a time.
// A pixel and each pixel of a glyph are a store read then a write, a clear zeroes every store
// byte (1024 at the default size), and a flush reads each column byte and stalls on output
// backpressure. After reset the block sweeps the store to zero, one byte a cycle, before
// in.ready rises. Depends on pfte_pkg, pfte_if.
module page_framebuffer_text_engine #(
  parameter int PANEL_WIDTH  = pfte_pkg::DEF_PANEL_WIDTH,
  parameter int PANEL_HEIGHT = pfte_pkg::DEF_PANEL_HEIGHT
) (
  input logic       clk,
  input logic       rst_n,
  pfte_in_if.sink   in_ch,
  pfte_out_if.source out_ch
);
  pfte_pkg::pfte_cmd_t cmd;
  pfte_pkg::pfte_sts_t sts;

  pfte_ctrl u_ctrl (
    .clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_operation(in_ch.operation), .cmd, .sts
  );

  pfte_datapath #(.PANEL_WIDTH(PANEL_WIDTH), .PANEL_HEIGHT(PANEL_HEIGHT)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .in_operation(in_ch.operation), .in_x_pos(in_ch.x_pos), .in_y_pos(in_ch.y_pos),
    .in_pixel_on(in_ch.pixel_on), .in_char_code(in_ch.char_code),
    .in_page_index(in_ch.page_index),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_bus_bytes(out_ch.bus_bytes),
    .out_byte_count(out_ch.byte_count), .out_transfer_start(out_ch.transfer_start),
    .out_transfer_end(out_ch.transfer_end), .out_last_of_flush(out_ch.last_of_flush)
  );

  // a stalled word must hold
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.bus_bytes))
    else $error("output word changed under stall");
  // last word of a flush always closes its transfer
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.last_of_flush |-> out_ch.transfer_end)
    else $error("last word without stop");
  // no item taken while a store write is in flight
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.pix_wr || cmd.clr_wr) |-> !in_ch.ready)
    else $error("ready during store update");
endmodule

[tb/page_framebuffer_text_engine_test.sv]
// testbench for page_framebuffer_text_engine: drives draw, clear and page flush items and
// checks every transfer word against a frame store model kept here
// depends on pfte_pkg, pfte_if and the block
`timescale 1ns / 1ps

module page_framebuffer_text_engine_test;

  localparam int PW = pfte_pkg::DEF_PANEL_WIDTH;
  localparam int PH = pfte_pkg::DEF_PANEL_HEIGHT;
  localparam int WATCH_LIMIT = 20000;

  typedef struct packed {
    logic [63:0] bytes;
    logic [3:0]  count;
    logic        start;
    logic        stop;
    logic        last;
  } bus_word_t;

  logic clk;
  logic rst_n;
  pfte_in_if in_ch ();
  pfte_out_if out_ch ();

  page_framebuffer_text_engine dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [7:0] shadow_store [0:PW*pfte_pkg::NUM_PAGES-1];
  bus_word_t  expected_words [$];
  int errors;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_cycles;
  int quiet_cycles;

  function automatic logic [7:0] font_column(input logic [7:0] code, input int col);
    logic [7:0] f [0:4];
    case (code)
      8'd48: f = '{8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E};
      8'd49: f = '{8'h00, 8'h42, 8'h7F, 8'h40, 8'h00};
      8'd50: f = '{8'h42, 8'h61, 8'h51, 8'h49, 8'h46};
      8'd51: f = '{8'h21, 8'h41, 8'h45, 8'h4B, 8'h31};
      8'd65: f = '{8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E};
      8'd66: f = '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h36};
      8'd67: f = '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h22};
      default: f = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    endcase
    return f[col];
  endfunction

  function automatic void plot(input int x, input int y, input logic on);
    int idx;
    if (x < 0 || x >= PW || y < 0 || y >= PH) return;
    idx = (y / 8) * PW + x;
    shadow_store[idx][y % 8] = on;
  endfunction

  function automatic bus_word_t make_word(input logic [63:0] b, input int n,
                                         input logic s, input logic e, input logic l);
    bus_word_t w;
    w.bytes = b; w.count = n[3:0]; w.start = s; w.stop = e; w.last = l;
    return w;
  endfunction

  // update the store copy and queue the words a flush produces
  function automatic void predict_item(input pfte_pkg::op_t op, input int x, input int y,
                                       input logic on, input logic [7:0] code,
                                       input logic [2:0] page);
    int ncols, total, words, s, cnt;
    logic [63:0] b;
    logic [7:0] colbits;
    case (op)
      pfte_pkg::OP_CLEAR: foreach (shadow_store[i]) shadow_store[i] = 8'h00;
      pfte_pkg::OP_PIXEL: plot(x, y, on);
      pfte_pkg::OP_GLYPH: begin
        if (code >= pfte_pkg::FIRST_CODE && code <= pfte_pkg::LAST_CODE)
          for (int c = 0; c < 5; c++) begin
            colbits = font_column(code, c);
            for (int r = 0; r < 7; r++) plot(x + c, y + r, colbits[r]);
          end
      end
      pfte_pkg::OP_SHOW: begin
        expected_words.push_back(make_word({48'h0, pfte_pkg::CMD_PAGE + 8'(page),
                                            pfte_pkg::CMD_CTRL}, 2, 1, 1, 0));
        expected_words.push_back(make_word({48'h0, pfte_pkg::CMD_COL_LO, pfte_pkg::CMD_CTRL},
                                           2, 1, 1, 0));
        expected_words.push_back(make_word({48'h0, pfte_pkg::CMD_COL_HI, pfte_pkg::CMD_CTRL},
                                           2, 1, 1, 0));
        ncols = PW < pfte_pkg::MAX_DATA_COLS ? PW : pfte_pkg::MAX_DATA_COLS;
        total = ncols + 1;
        words = (total + 7) / 8;
        for (int w = 0; w < words; w++) begin
          b = '0;
          cnt = 0;
          for (int k = 0; k < 8; k++) begin
            s = w * 8 + k;
            if (s < total) begin
              b[8*k +: 8] = (s == 0) ? pfte_pkg::DATA_CTRL : shadow_store[page * PW + s - 1];
              cnt++;
            end
          end
          expected_words.push_back(make_word(b, cnt, w == 0, w == words - 1,
                                             w == words - 1));
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(input pfte_pkg::op_t op, input int x, input int y, input logic on,
                           input logic [7:0] code, input logic [2:0] page);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.operation  <= op;
    in_ch.x_pos      <= 10'(x);
    in_ch.y_pos      <= 10'(y);
    in_ch.pixel_on   <= on;
    in_ch.char_code  <= code;
    in_ch.page_index <= page;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_item(op, x, y, on, code, page);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    // a clear can still be sweeping when the last word arrives
    repeat (1200) @(posedge clk);
  endtask

  // random signed position, mostly near the panel, sometimes anywhere
  function automatic int rand_pos(input int span);
    if ($urandom_range(9) == 0) return int'($urandom_range(1023)) - 512;
    return int'($urandom_range(span + 15)) - 8;
  endfunction

  task automatic random_item(input int show_pct);
    int r;
    r = $urandom_range(99);
    if (r < show_pct)
      send_item(pfte_pkg::OP_SHOW, rand_pos(PW), rand_pos(PH), 1'($urandom_range(1)),
                8'($urandom_range(255)), 3'($urandom_range(7)));
    else if (r < show_pct + 2)
      send_item(pfte_pkg::OP_CLEAR, rand_pos(PW), rand_pos(PH), 1'($urandom_range(1)),
                8'($urandom_range(255)), 3'($urandom_range(7)));
    else if (r < 60)
      send_item(pfte_pkg::OP_PIXEL, rand_pos(PW), rand_pos(PH), 1'($urandom_range(1)),
                8'($urandom_range(255)), 3'($urandom_range(7)));
    else
      send_item(pfte_pkg::OP_GLYPH, rand_pos(PW), rand_pos(PH), 1'($urandom_range(1)),
                $urandom_range(3) == 0 ? 8'($urandom_range(255))
                                       : 8'($urandom_range(47, 67)),
                3'($urandom_range(7)));
  endtask

  task automatic test_edges();
    send_item(pfte_pkg::OP_SHOW, 0, 0, 0, 8'd0, 3'd0);
    send_item(pfte_pkg::OP_PIXEL, 0, 0, 1, 8'd255, 3'd7);
    send_item(pfte_pkg::OP_PIXEL, PW - 1, PH - 1, 1, 8'd0, 3'd7);
    send_item(pfte_pkg::OP_PIXEL, -1, 5, 1, 8'd0, 3'd0);
    send_item(pfte_pkg::OP_PIXEL, PW, 5, 1, 8'd0, 3'd0);
    send_item(pfte_pkg::OP_PIXEL, 5, PH, 1, 8'd0, 3'd0);
    send_item(pfte_pkg::OP_PIXEL, -512, -512, 1, 8'd0, 3'd0);
    send_item(pfte_pkg::OP_PIXEL, 511, 511, 1, 8'd0, 3'd0);
    send_item(pfte_pkg::OP_PIXEL, 3, 3, 1, 8'd0, 3'd0);
    send_item(pfte_pkg::OP_PIXEL, 3, 3, 0, 8'd0, 3'd0);
    send_item(pfte_pkg::OP_GLYPH, 10, 2, 0, 8'd65, 3'd0);
    send_item(pfte_pkg::OP_GLYPH, 20, 60, 1, 8'd48, 3'd0);
    send_item(pfte_pkg::OP_GLYPH, PW - 2, -3, 0, 8'd66, 3'd0);
    send_item(pfte_pkg::OP_GLYPH, 10, 2, 0, 8'd31, 3'd0);
    send_item(pfte_pkg::OP_GLYPH, 16, 2, 0, 8'd128, 3'd0);
    send_item(pfte_pkg::OP_GLYPH, 10, 2, 0, 8'd255, 3'd0);
    send_item(pfte_pkg::OP_GLYPH, 30, 10, 1, 8'd127, 3'd0);
    send_item(pfte_pkg::OP_GLYPH, 40, 10, 0, 8'd67, 3'd0);
    send_item(pfte_pkg::OP_SHOW, 0, 0, 0, 8'd0, 3'd0);
    send_item(pfte_pkg::OP_SHOW, 0, 0, 0, 8'd0, 3'd7);
    send_item(pfte_pkg::OP_SHOW, 0, 0, 0, 8'd0, 3'd1);
    send_item(pfte_pkg::OP_CLEAR, 0, 0, 0, 8'd0, 3'd0);
    send_item(pfte_pkg::OP_SHOW, 0, 0, 0, 8'd0, 3'd0);
  endtask

  task automatic test_random_phase(input int n, input int idle, input int stall);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    repeat (n) random_item(12);
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 3000;
    repeat (6) send_item(pfte_pkg::OP_SHOW, 0, 0, 0, 8'd0, 3'($urandom_range(7)));
    wait_drained();
  endtask

  // receiver, with a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles  <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    bus_word_t exp_w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_words.size() == 0) begin
        $error("unexpected transfer word %h", out_ch.bus_bytes);
        errors++;
      end else begin
        exp_w = expected_words.pop_front();
        if (out_ch.bus_bytes !== exp_w.bytes) begin
          $error("bus_bytes exp %h got %h", exp_w.bytes, out_ch.bus_bytes); errors++;
        end
        if (out_ch.byte_count !== exp_w.count) begin
          $error("byte_count exp %0d got %0d", exp_w.count, out_ch.byte_count); errors++;
        end
        if (out_ch.transfer_start !== exp_w.start) begin
          $error("transfer_start exp %b got %b", exp_w.start, out_ch.transfer_start);
          errors++;
        end
        if (out_ch.transfer_end !== exp_w.stop) begin
          $error("transfer_end exp %b got %b", exp_w.stop, out_ch.transfer_end); errors++;
        end
        if (out_ch.last_of_flush !== exp_w.last) begin
          $error("last_of_flush exp %b got %b", exp_w.last, out_ch.last_of_flush);
          errors++;
        end
      end
    end
  end

  // watchdog on transfers; post-reset sweep counts as quiet time too
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || hold_cycles > 0)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCH_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    errors = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    quiet_cycles = 0;
    in_ch.valid = 1'b0;
    in_ch.operation = pfte_pkg::OP_CLEAR;
    in_ch.x_pos = '0;
    in_ch.y_pos = '0;
    in_ch.pixel_on = 1'b0;
    in_ch.char_code = '0;
    in_ch.page_index = '0;
    foreach (shadow_store[i]) shadow_store[i] = 8'h00;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_edges();
    test_backpressure();
    test_random_phase(100, 0, 0);
    test_random_phase(100, 76, 0);
    test_random_phase(100, 0, 76);
    test_random_phase(100, 16, 16);
    wait_drained();
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule
